// ===== hdl/bmh_pkg.sv =====
// Shared types for the bounded min-heap top-K unit: micro-op and condition codes,
// the control word, sequencer addresses and the datapath status bundle.
// No dependencies.
package bmh_pkg;

  localparam logic [4:0] LIMIT_RESET = 5'd16;
  localparam int UPC_BITS = 4;

  typedef enum logic [3:0] {
    OP_NONE       = 4'd0,
    OP_LOAD       = 4'd1,
    OP_APPEND     = 4'd2,
    OP_READ_PAR   = 4'd3,
    OP_UP_MOVE    = 4'd4,
    OP_EVICT      = 4'd5,
    OP_READ_LEFT  = 4'd6,
    OP_CAP_LEFT   = 4'd7,
    OP_PICK_RIGHT = 4'd8,
    OP_DOWN_MOVE  = 4'd9,
    OP_PLACE      = 4'd10,
    OP_EMIT       = 4'd11
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER       = 4'd0,
    C_ALWAYS      = 4'd1,
    C_NO_ITEM     = 4'd2,
    C_ROOM        = 4'd3,
    C_NO_BEAT     = 4'd4,
    C_AT_ROOT     = 4'd5,
    C_NOT_LESS_RD = 4'd6,
    C_NO_KID      = 4'd7,
    C_NO_RIGHT    = 4'd8,
    C_ITEM_LESS_C = 4'd9,
    C_OUT_FREE    = 4'd10
  } cond_t;

  typedef logic [UPC_BITS-1:0] upc_t;

  // microprogram addresses
  localparam upc_t UA_IDLE     = 4'd0;
  localparam upc_t UA_ROOM     = 4'd1;
  localparam upc_t UA_BEAT     = 4'd2;
  localparam upc_t UA_DN_INIT  = 4'd3;
  localparam upc_t UA_DN_TEST  = 4'd4;
  localparam upc_t UA_DN_LEFT  = 4'd5;
  localparam upc_t UA_DN_RIGHT = 4'd6;
  localparam upc_t UA_DN_CMP   = 4'd7;
  localparam upc_t UA_DN_MOVE  = 4'd8;
  localparam upc_t UA_UP_INIT  = 4'd9;
  localparam upc_t UA_UP_TEST  = 4'd10;
  localparam upc_t UA_UP_WAIT  = 4'd11;
  localparam upc_t UA_UP_MOVE  = 4'd12;
  localparam upc_t UA_PLACE    = 4'd13;
  localparam upc_t UA_FINISH   = 4'd14;
  localparam upc_t UA_FIN_WAIT = 4'd15;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } ctrl_t;

  typedef struct packed {
    logic item_valid;
    logic out_free;
    logic room;
    logic beat;
    logic at_root;
    logic not_less_rd;
    logic no_kid;
    logic no_right;
    logic item_less_c;
  } status_t;

endpackage

// ===== hdl/bmh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int ADDR_BITS = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bmh_seq.sv =====
// Microcode sequencer: step counter, control-word ROM and jump logic.
// Depends on bmh_pkg.
module bmh_seq (
  input  logic             clk,
  input  logic             rst,
  input  bmh_pkg::status_t status,
  output bmh_pkg::ctrl_t   ctrl
);

  bmh_pkg::upc_t upc;
  bmh_pkg::upc_t upc_next;
  logic          take;

  // jump taken: go to target, else fall through to the next step
  function automatic bmh_pkg::ctrl_t rom(input bmh_pkg::upc_t a);
    bmh_pkg::ctrl_t w;
    w = '{op: bmh_pkg::OP_NONE, cond: bmh_pkg::C_ALWAYS, target: bmh_pkg::UA_IDLE};
    case (a)
      bmh_pkg::UA_IDLE:     w = '{bmh_pkg::OP_LOAD, bmh_pkg::C_NO_ITEM, bmh_pkg::UA_IDLE};
      bmh_pkg::UA_ROOM:     w = '{bmh_pkg::OP_NONE, bmh_pkg::C_ROOM, bmh_pkg::UA_UP_INIT};
      bmh_pkg::UA_BEAT:     w = '{bmh_pkg::OP_NONE, bmh_pkg::C_NO_BEAT, bmh_pkg::UA_FINISH};
      bmh_pkg::UA_DN_INIT:  w = '{bmh_pkg::OP_EVICT, bmh_pkg::C_NEVER, bmh_pkg::UA_IDLE};
      bmh_pkg::UA_DN_TEST:  w = '{bmh_pkg::OP_READ_LEFT, bmh_pkg::C_NO_KID, bmh_pkg::UA_PLACE};
      bmh_pkg::UA_DN_LEFT:  w = '{bmh_pkg::OP_CAP_LEFT, bmh_pkg::C_NO_RIGHT, bmh_pkg::UA_DN_CMP};
      bmh_pkg::UA_DN_RIGHT: w = '{bmh_pkg::OP_PICK_RIGHT, bmh_pkg::C_NEVER, bmh_pkg::UA_IDLE};
      bmh_pkg::UA_DN_CMP:   w = '{bmh_pkg::OP_NONE, bmh_pkg::C_ITEM_LESS_C, bmh_pkg::UA_PLACE};
      bmh_pkg::UA_DN_MOVE:  w = '{bmh_pkg::OP_DOWN_MOVE, bmh_pkg::C_ALWAYS, bmh_pkg::UA_DN_TEST};
      bmh_pkg::UA_UP_INIT:  w = '{bmh_pkg::OP_APPEND, bmh_pkg::C_NEVER, bmh_pkg::UA_IDLE};
      bmh_pkg::UA_UP_TEST:  w = '{bmh_pkg::OP_READ_PAR, bmh_pkg::C_AT_ROOT, bmh_pkg::UA_PLACE};
      // keep the parent address on the read port so the move step sees its word
      bmh_pkg::UA_UP_WAIT:  w = '{bmh_pkg::OP_READ_PAR, bmh_pkg::C_NOT_LESS_RD, bmh_pkg::UA_PLACE};
      bmh_pkg::UA_UP_MOVE:  w = '{bmh_pkg::OP_UP_MOVE, bmh_pkg::C_ALWAYS, bmh_pkg::UA_UP_TEST};
      bmh_pkg::UA_PLACE:    w = '{bmh_pkg::OP_PLACE, bmh_pkg::C_NEVER, bmh_pkg::UA_IDLE};
      bmh_pkg::UA_FINISH:   w = '{bmh_pkg::OP_EMIT, bmh_pkg::C_OUT_FREE, bmh_pkg::UA_IDLE};
      bmh_pkg::UA_FIN_WAIT: w = '{bmh_pkg::OP_NONE, bmh_pkg::C_ALWAYS, bmh_pkg::UA_FINISH};
      default:              w = '{bmh_pkg::OP_NONE, bmh_pkg::C_ALWAYS, bmh_pkg::UA_IDLE};
    endcase
    return w;
  endfunction

  assign ctrl = rom(upc);

  always_comb begin
    case (ctrl.cond)
      bmh_pkg::C_NEVER:       take = 1'b0;
      bmh_pkg::C_ALWAYS:      take = 1'b1;
      bmh_pkg::C_NO_ITEM:     take = !status.item_valid;
      bmh_pkg::C_ROOM:        take = status.room;
      bmh_pkg::C_NO_BEAT:     take = !status.beat;
      bmh_pkg::C_AT_ROOT:     take = status.at_root;
      bmh_pkg::C_NOT_LESS_RD: take = status.not_less_rd;
      bmh_pkg::C_NO_KID:      take = status.no_kid;
      bmh_pkg::C_NO_RIGHT:    take = status.no_right;
      bmh_pkg::C_ITEM_LESS_C: take = status.item_less_c;
      bmh_pkg::C_OUT_FREE:    take = status.out_free;
      default:                take = 1'b1;
    endcase
    upc_next = take ? ctrl.target : upc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= bmh_pkg::UA_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// ===== hdl/bmh_dp.sv =====
// Heap datapath: item, cursor and child registers, fill count, root copy,
// limit register and the heap RAM, all driven by the control word.
// Depends on bmh_pkg and bmh_ram.
module bmh_dp #(
  parameter int CAPACITY = 16,
  parameter int WEIGHT_BITS = 32,
  parameter int TAG_BITS = 32,
  parameter int ADDR_BITS = 4,
  parameter int COUNT_BITS = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bmh_pkg::ctrl_t         ctrl,
  input  logic                   in_valid,
  input  logic                   out_free,
  input  logic [WEIGHT_BITS-1:0] in_weight,
  input  logic [TAG_BITS-1:0]    in_tag,
  input  logic                   cfg_we,
  input  logic [4:0]             cfg_wdata,
  output bmh_pkg::status_t       status,
  output logic                   accepted,
  output logic                   displaced,
  output logic [WEIGHT_BITS-1:0] evicted_weight,
  output logic [TAG_BITS-1:0]    evicted_tag,
  output logic [COUNT_BITS-1:0]  count,
  output logic [WEIGHT_BITS-1:0] root_weight
);

  localparam int WORD = WEIGHT_BITS + TAG_BITS;
  localparam int XW = ADDR_BITS + 2;
  localparam int LW = (XW > 5) ? XW : 5;

  logic [WEIGHT_BITS-1:0] item_w;
  logic [TAG_BITS-1:0]    item_t;
  logic [ADDR_BITS-1:0]   pos;
  logic [ADDR_BITS-1:0]   kid;
  logic [WEIGHT_BITS-1:0] c_w;
  logic [TAG_BITS-1:0]    c_t;
  logic [TAG_BITS-1:0]    root_t;
  logic [4:0]             element_limit;

  logic                   we;
  logic [ADDR_BITS-1:0]   waddr;
  logic [ADDR_BITS-1:0]   raddr;
  logic [WORD-1:0]        wdata;
  logic [WORD-1:0]        rdata;
  logic [WEIGHT_BITS-1:0] rd_w;
  logic [TAG_BITS-1:0]    rd_t;
  logic [ADDR_BITS-1:0]   par;
  logic [XW-1:0]          kid_l;
  logic [XW-1:0]          kid_r;
  logic [XW-1:0]          count_x;
  logic                   load;

  assign rd_w    = rdata[WEIGHT_BITS-1:0];
  assign rd_t    = rdata[WEIGHT_BITS +: TAG_BITS];
  assign par     = ADDR_BITS'((pos - 1'b1) >> 1);
  assign kid_l   = {1'b0, pos, 1'b1};
  assign kid_r   = XW'(kid) + 1'b1;
  assign count_x = XW'(count);
  assign load    = (ctrl.op == bmh_pkg::OP_LOAD) && in_valid;

  always_comb begin
    status.item_valid  = in_valid;
    status.out_free    = out_free;
    status.room        = (LW'(count) < LW'(element_limit)) && (LW'(count) < LW'(CAPACITY));
    status.beat        = (element_limit != '0) && (count != '0)
                         && ($signed(root_weight) < $signed(item_w));
    status.at_root     = (pos == '0);
    status.not_less_rd = !($signed(item_w) < $signed(rd_w));
    status.no_kid      = (kid_l >= count_x);
    status.no_right    = (kid_r >= count_x);
    status.item_less_c = $signed(item_w) < $signed(c_w);
  end

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = {item_t, item_w};
    raddr = '0;
    case (ctrl.op)
      bmh_pkg::OP_READ_PAR:  raddr = par;
      bmh_pkg::OP_READ_LEFT: raddr = ADDR_BITS'(kid_l);
      bmh_pkg::OP_CAP_LEFT:  raddr = ADDR_BITS'(kid_r);
      bmh_pkg::OP_UP_MOVE: begin
        we    = 1'b1;
        wdata = rdata;
      end
      bmh_pkg::OP_DOWN_MOVE: begin
        we    = 1'b1;
        wdata = {c_t, c_w};
      end
      bmh_pkg::OP_PLACE:     we = 1'b1;
      default:               raddr = '0;
    endcase
  end

  bmh_ram #(
    .WIDTH(WORD),
    .DEPTH(CAPACITY),
    .ADDR_BITS(ADDR_BITS)
  ) u_ram (
    .clk(clk),
    .we(we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      element_limit <= bmh_pkg::LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        element_limit <= cfg_wdata;
      end
      if (ctrl.op == bmh_pkg::OP_APPEND) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_w         <= in_weight;
      item_t         <= in_tag;
      accepted       <= 1'b0;
      displaced      <= 1'b0;
      evicted_weight <= '0;
      evicted_tag    <= '0;
    end
    case (ctrl.op)
      bmh_pkg::OP_APPEND: begin
        pos      <= ADDR_BITS'(count);
        accepted <= 1'b1;
      end
      bmh_pkg::OP_EVICT: begin
        pos            <= '0;
        accepted       <= 1'b1;
        displaced      <= 1'b1;
        evicted_weight <= root_weight;
        evicted_tag    <= root_t;
      end
      bmh_pkg::OP_UP_MOVE:   pos <= par;
      bmh_pkg::OP_READ_LEFT: kid <= ADDR_BITS'(kid_l);
      bmh_pkg::OP_CAP_LEFT: begin
        c_w <= rd_w;
        c_t <= rd_t;
      end
      bmh_pkg::OP_PICK_RIGHT: begin
        // right child only if strictly lighter than the left
        if ($signed(rd_w) < $signed(c_w)) begin
          c_w <= rd_w;
          c_t <= rd_t;
          kid <= ADDR_BITS'(kid_r);
        end
      end
      bmh_pkg::OP_DOWN_MOVE: pos <= kid;
      default: ;
    endcase
    // shadow copy of entry 0
    if (we && waddr == '0) begin
      root_weight <= wdata[WEIGHT_BITS-1:0];
      root_t      <= wdata[WEIGHT_BITS +: TAG_BITS];
    end
  end

endmodule

// ===== hdl/bounded_min_heap_top_k_unit.sv =====
// Top level of the bounded min-heap top-K unit: stream ports, result register.
// Depends on bmh_pkg, bmh_seq, bmh_dp (and bmh_ram below it).
//
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  tdata: item_weight, item_tag
// m_*       out        m_tvalid/m_tready  tdata: evicted_weight, evicted_tag,
//                                          entry_count, min_weight; tuser: accepted, displaced
// cfg_*     in         cfg_we             cfg_wdata: element_limit
//
// Each item runs as microcode steps: a reject tests room and beat and goes to the
// finish step; an append reads the parent, compares and moves once per level climbed;
// a replace evicts the root, reads the left and right child, picks one, compares and
// moves once per level descended; both end by placing the item. Levels up to
// log2(CAPACITY). One RAM read port with registered read; one step per read, compare or move.
// Reset (rst, synchronous) empties the heap and sets the limit to 16.
// A finished result sits in the output register; the sequencer holds in its
// finish step until that register is free, and takes the next item after it.
module bounded_min_heap_top_k_unit #(
  parameter int CAPACITY = 16,
  parameter int WEIGHT_BITS = 32,
  parameter int TAG_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // [WEIGHT_BITS-1:0] item_weight, then item_tag, zero pad to bytes
  input  logic [((WEIGHT_BITS+TAG_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // evicted_weight, evicted_tag, entry_count (5), min_weight, zero pad to bytes
  output logic [((2*WEIGHT_BITS+TAG_BITS+5+7)/8)*8-1:0] m_tdata,
  // [0] accepted, [1] displaced
  output logic [1:0] m_tuser,
  input  logic cfg_we,
  input  logic [4:0] cfg_wdata
);

  localparam int ADDR_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);
  localparam int RAW_OUT = 2 * WEIGHT_BITS + TAG_BITS + 5;

  bmh_pkg::ctrl_t   ctrl;
  bmh_pkg::status_t status;

  logic                   out_free;
  logic                   dp_acc;
  logic                   dp_disp;
  logic [WEIGHT_BITS-1:0] dp_ev_w;
  logic [TAG_BITS-1:0]    dp_ev_t;
  logic [COUNT_BITS-1:0]  dp_count;
  logic [WEIGHT_BITS-1:0] dp_root_w;
  logic [RAW_OUT-1:0]     out_data;
  logic [WEIGHT_BITS-1:0] min_w;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (ctrl.op == bmh_pkg::OP_LOAD);
  assign min_w    = (dp_count != '0) ? dp_root_w : '0;

  bmh_seq u_seq (
    .clk(clk),
    .rst(rst),
    .status(status),
    .ctrl(ctrl)
  );

  bmh_dp #(
    .CAPACITY(CAPACITY),
    .WEIGHT_BITS(WEIGHT_BITS),
    .TAG_BITS(TAG_BITS),
    .ADDR_BITS(ADDR_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .ctrl(ctrl),
    .in_valid(s_tvalid),
    .out_free(out_free),
    .in_weight(s_tdata[WEIGHT_BITS-1:0]),
    .in_tag(s_tdata[WEIGHT_BITS +: TAG_BITS]),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .status(status),
    .accepted(dp_acc),
    .displaced(dp_disp),
    .evicted_weight(dp_ev_w),
    .evicted_tag(dp_ev_t),
    .count(dp_count),
    .root_weight(dp_root_w)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.op == bmh_pkg::OP_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == bmh_pkg::OP_EMIT && out_free) begin
      out_data <= {min_w, 5'(dp_count), dp_ev_t, dp_ev_w};
      m_tuser  <= {dp_disp, dp_acc};
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[RAW_OUT-1:0] = out_data;
  end

  a_disp_acc: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tuser[1] || m_tuser[0]))
    else $error("displaced result not marked accepted");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> (dp_count <= COUNT_BITS'(CAPACITY)))
    else $error("fill count above capacity");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item taken while one is in work");

  a_disp_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tdata[WEIGHT_BITS+TAG_BITS +: 5] != 5'd0))
    else $error("replacement reported on an empty heap");

endmodule

// ===== tb/top_k_checker.sv =====
`timescale 1ns / 1ps
// Checker for the bounded min-heap top-K unit: watches the item, result and limit
// channels, keeps its own copy of the heap and compares every result field by field.
// Depends on bmh_pkg for the reset value of the limit.
module top_k_checker #(
  parameter int CAPACITY = 16,
  parameter int WEIGHT_BITS = 32,
  parameter int TAG_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tready,
  // item_weight, item_tag, zero pad
  input  logic [((WEIGHT_BITS+TAG_BITS+7)/8)*8-1:0] s_tdata,
  input  logic m_tvalid,
  input  logic m_tready,
  // evicted_weight, evicted_tag, entry_count, min_weight, zero pad
  input  logic [((2*WEIGHT_BITS+TAG_BITS+5+7)/8)*8-1:0] m_tdata,
  // accepted, displaced
  input  logic [1:0] m_tuser,
  input  logic cfg_we,
  input  logic [4:0] cfg_wdata,
  output int fail_count,
  output int pending,
  output logic signed [WEIGHT_BITS-1:0] root_hint
);

  localparam int W = WEIGHT_BITS;
  localparam int T = TAG_BITS;

  typedef struct packed {
    logic accepted;
    logic displaced;
    logic signed [W-1:0] evicted_weight;
    logic [T-1:0] evicted_tag;
    logic [4:0] entry_count;
    logic signed [W-1:0] min_weight;
  } heap_outcome_t;

  logic signed [W-1:0] heap_wt [CAPACITY];
  logic [T-1:0] heap_tag [CAPACITY];
  int fill = 0;
  logic [4:0] limit_reg = bmh_pkg::LIMIT_RESET;

  heap_outcome_t outcome_q [$];
  int n_fail = 0;

  assign fail_count = n_fail;

  // Offer one item to the shadow heap and return what the block should report.
  function automatic heap_outcome_t offer_to_heap(logic signed [W-1:0] w, logic [T-1:0] t);
    heap_outcome_t r;
    int lim;
    int pos;
    int par;
    int kid;
    r = '0;
    lim = (limit_reg > CAPACITY) ? CAPACITY : int'(limit_reg);
    if (fill < lim) begin
      pos = fill;
      fill++;
      while (pos != 0) begin
        par = (pos - 1) / 2;
        if (!(w < heap_wt[par])) break;
        heap_wt[pos] = heap_wt[par];
        heap_tag[pos] = heap_tag[par];
        pos = par;
      end
      heap_wt[pos] = w;
      heap_tag[pos] = t;
      r.accepted = 1'b1;
    end else if (lim != 0 && fill != 0 && heap_wt[0] < w) begin
      r.evicted_weight = heap_wt[0];
      r.evicted_tag = heap_tag[0];
      pos = 0;
      forever begin
        kid = 2 * pos + 1;
        if (kid >= fill) break;
        // right child only when strictly lighter than the left
        if (kid + 1 < fill && heap_wt[kid+1] < heap_wt[kid]) kid++;
        if (w < heap_wt[kid]) break;
        heap_wt[pos] = heap_wt[kid];
        heap_tag[pos] = heap_tag[kid];
        pos = kid;
      end
      heap_wt[pos] = w;
      heap_tag[pos] = t;
      r.accepted = 1'b1;
      r.displaced = 1'b1;
    end
    r.entry_count = fill[4:0];
    r.min_weight = (fill != 0) ? heap_wt[0] : '0;
    return r;
  endfunction

  task automatic compare_field(input string fname, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", fname, exp_v, act_v);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    heap_outcome_t e;
    if (rst) begin
      fill = 0;
      limit_reg = bmh_pkg::LIMIT_RESET;
      outcome_q.delete();
      pending = 0;
      root_hint = '0;
    end else begin
      if (cfg_we) limit_reg = cfg_wdata;
      if (m_tvalid && m_tready) begin
        if (outcome_q.size() == 0) begin
          $error("result item with no item outstanding");
          n_fail++;
        end else begin
          e = outcome_q.pop_front();
          compare_field("accepted", e.accepted, m_tuser[0]);
          compare_field("displaced", e.displaced, m_tuser[1]);
          compare_field("evicted_weight", e.evicted_weight, $signed(m_tdata[W-1:0]));
          compare_field("evicted_tag", e.evicted_tag, m_tdata[W+T-1:W]);
          compare_field("entry_count", e.entry_count, m_tdata[W+T+4:W+T]);
          compare_field("min_weight", e.min_weight, $signed(m_tdata[2*W+T+4:W+T+5]));
        end
      end
      if (s_tvalid && s_tready)
        outcome_q.insert(outcome_q.size(),
                         offer_to_heap(s_tdata[W-1:0], s_tdata[W+T-1:W]));
      pending = outcome_q.size();
      root_hint = (fill != 0) ? heap_wt[0] : '0;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the bounded min-heap top-K unit: clock, reset, item and limit
// stimulus with random idling on both channels, and the verdict.
// Depends on bounded_min_heap_top_k_unit and top_k_checker.
module tb;

  localparam int CAPACITY = 16;
  localparam int W = 32;
  localparam int T = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 80;
  localparam logic signed [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [((W+T+7)/8)*8-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [((2*W+T+5+7)/8)*8-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  logic signed [W-1:0] root_hint;

  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int n_items = 0;
  int n_cfg = 0;

  bounded_min_heap_top_k_unit #(
    .CAPACITY(CAPACITY), .WEIGHT_BITS(W), .TAG_BITS(T)
  ) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  top_k_checker #(
    .CAPACITY(CAPACITY), .WEIGHT_BITS(W), .TAG_BITS(T)
  ) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .root_hint(root_hint)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Hold valid low for a geometric number of cycles, then offer the item
  // and wait for it to be taken.
  task automatic send_item(input logic signed [W-1:0] w, input logic [T-1:0] t);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {t, w};
    do @(posedge clk); while (!s_tready);
    n_items++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [4:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
  endtask

  // Mostly weights close to the current root so that ties, replacements and
  // rejections all stay frequent; some full-range and extreme values.
  function automatic logic signed [W-1:0] pick_weight();
    int unsigned sel;
    longint x;
    sel = $urandom_range(99);
    if (sel < 8) return $urandom;
    if (sel < 13) begin
      case ($urandom_range(5))
        0: return W_MAX;
        1: return W_MAX - 1;
        2: return W_MIN;
        3: return W_MIN + 1;
        4: return '0;
        default: return '1;
      endcase
    end
    x = longint'(root_hint) + longint'($urandom_range(24)) - 12;
    if (x > longint'(W_MAX)) x = W_MAX;
    if (x < longint'(W_MIN)) x = W_MIN;
    return x[W-1:0];
  endfunction

  initial begin
    logic [4:0] phase_limits [13];
    phase_limits = '{5'd2, 5'd0, 5'd9, 5'd12, 5'd17, 5'd16, 5'd31, 5'd5, 5'd1, 5'd16,
                     5'd3, 5'd24, 5'd16};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // small heap: appends with a climb to the root, tie with the root,
    // replacement with equal children, extremes
    write_limit(5'd3);
    send_item(32'sd5, 32'h0000_0000);
    send_item(32'sd5, 32'hFFFF_FFFF);
    send_item(32'sd3, 32'h0000_0001);
    send_item(32'sd3, 32'h0000_0002);
    send_item(32'sd6, 32'h0000_0003);
    send_item(W_MIN, 32'h8000_0000);
    send_item(W_MAX, 32'h7FFF_FFFF);
    // zero limit with entries held
    write_limit(5'd0);
    send_item(W_MAX, 32'h0000_0006);
    send_item(32'sd0, 32'h0000_0007);
    // limit below the fill: replacement over all three entries
    write_limit(5'd1);
    send_item(W_MAX, 32'h5555_5555);
    send_item(32'sd6, 32'hAAAA_AAAA);
    // limit above capacity
    write_limit(5'd31);
    send_item(-32'sd1, 32'hFFFF_FFFF);
    send_item(W_MIN, 32'h0000_0000);
    send_item(32'sd0, 32'h1234_5678);
    send_item(32'sd1, 32'h8765_4321);
    send_item(W_MIN + 1, 32'hDEAD_BEEF);
    send_item(W_MAX - 1, 32'h0F0F_F0F0);

    for (int p = 0; p < 13; p++) begin
      write_limit(phase_limits[p]);
      case (p % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 79; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 79; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_item(pick_weight(), $urandom);
    end

    idle_pct = 0;
    stall_pct = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);

    $display("offered %0d items over %0d limit settings (0 to 31) and four idling mixes",
             n_items, n_cfg);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bmh_pkg.sv
hdl/bmh_ram.sv
hdl/bmh_seq.sv
hdl/bmh_dp.sv
hdl/bounded_min_heap_top_k_unit.sv
tb/top_k_checker.sv
tb/tb.sv
